@@ rtl/ordered_array_table_unit_assert.svh @@
// assertion macros used by the rtl datapath
`ifndef ORDERED_ARRAY_TABLE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define OAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/oat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package oat_pkg;

  localparam int Depth     = 16;
  localparam int AddrW     = $clog2(Depth);
  localparam int CntW      = $clog2(Depth + 1);
  localparam int WordW     = 32;
  localparam int PosW      = 5;
  localparam int CapW      = 5;
  localparam int FoundW    = 5;
  localparam int KindW     = 3;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 48;
  localparam int OutPadW   = OutTdataW - (2 + FoundW + WordW + CntW + 2);

  localparam logic [CapW-1:0] CapReset = CapW'(16);
  localparam logic [CntW-1:0] CntOne   = CntW'(1);
  localparam logic [CntW-1:0] CntDepth = CntW'(Depth);

  typedef enum logic [KindW-1:0] {
    K_APPEND = 3'd0,
    K_INSERT = 3'd1,
    K_DELETE = 3'd2,
    K_SEARCH = 3'd3,
    K_READ   = 3'd4,
    K_CLEAR  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADIDX   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic    req_load;
    logic    st_load;
    status_e st_code;
    logic    app_wr;
    logic    clr;
    logic    ins_start;
    logic    shift_step;
    logic    ins_fin;
    logic    scan_start;
    logic    scan_step;
    logic    scan_fin;
    logic    rd_issue;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  pos_ok;
    logic  rd_ok;
    logic  shift_busy;
    logic  scan_busy;
    logic  hit;
    logic  out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/oat_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module oat_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/oat_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module oat_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire oat_pkg::dp_sts_t sts_i,
  output oat_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FIN    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st_code = oat_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_FIN;
        cmd_o.st_load = 1'b1;
        case (sts_i.kind)
          oat_pkg::K_APPEND: begin
            if (sts_i.full) begin
              cmd_o.st_code = oat_pkg::ST_FULL;
            end else begin
              cmd_o.app_wr = 1'b1;
            end
          end
          oat_pkg::K_INSERT: begin
            if (sts_i.full) begin
              cmd_o.st_code = oat_pkg::ST_FULL;
            end else if (!sts_i.pos_ok) begin
              cmd_o.st_code = oat_pkg::ST_BADIDX;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d = S_SHIFT;
            end
          end
          oat_pkg::K_DELETE, oat_pkg::K_SEARCH: begin
            cmd_o.st_load    = 1'b0;
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN;
          end
          oat_pkg::K_READ: begin
            if (sts_i.rd_ok) begin
              cmd_o.rd_issue = 1'b1;
            end else begin
              cmd_o.st_code = oat_pkg::ST_BADIDX;
            end
          end
          oat_pkg::K_CLEAR: begin
            cmd_o.clr = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        if (sts_i.shift_busy) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          cmd_o.ins_fin = 1'b1;
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_busy) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.st_load  = 1'b1;
          cmd_o.st_code  = sts_i.hit ? oat_pkg::ST_OK : oat_pkg::ST_NOTFOUND;
          cmd_o.scan_fin = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/oat_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_array_table_unit_assert.svh"

module oat_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [oat_pkg::CapW-1:0]       cfg_data_i,
  input  wire logic [oat_pkg::InTdataW-1:0]   in_tdata_i,
  input  wire logic [oat_pkg::KindW-1:0]      in_tuser_i,
  input  wire oat_pkg::dp_cmd_t               cmd_i,
  output oat_pkg::dp_sts_t                    sts_o,
  output logic                                out_tvalid_o,
  input  wire logic                           out_tready_i,
  output logic [oat_pkg::OutTdataW-1:0]       out_tdata_o
);

  logic [oat_pkg::CapW-1:0]      cap_q;
  logic [oat_pkg::CntW-1:0]      count_q;
  oat_pkg::kind_e                kind_q;
  logic [oat_pkg::WordW-1:0]     value_q;
  logic [oat_pkg::PosW-1:0]      pos_q;
  oat_pkg::status_e              status_q;
  logic [oat_pkg::CntW-1:0]      idx_q;
  logic [oat_pkg::AddrW-1:0]     tgt_q;
  logic                          rv_q;
  logic                          hit_q;
  logic [oat_pkg::AddrW-1:0]     hit_idx_q;
  logic                          out_valid_q;
  logic [oat_pkg::OutTdataW-1:0] out_data_q;

  logic                          ram_we;
  logic [oat_pkg::AddrW-1:0]     ram_waddr;
  logic [oat_pkg::WordW-1:0]     ram_wdata;
  logic                          ram_re;
  logic [oat_pkg::AddrW-1:0]     ram_raddr;
  logic [oat_pkg::WordW-1:0]     ram_rdata;

  logic                          full;
  logic                          issue_sh;
  logic                          issue_sc;
  logic                          match;
  logic                          is_del;
  logic [oat_pkg::CntW-1:0]      idx_m1;
  logic [oat_pkg::PosW-1:0]      pos_m1;
  logic [oat_pkg::WordW-1:0]     rd_res;
  logic [oat_pkg::FoundW-1:0]    found_res;

  oat_ram #(
    .Width (oat_pkg::WordW),
    .Depth (oat_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // capacity above depth behaves as depth
  assign full     = (count_q >= oat_pkg::CntW'(cap_q)) || (count_q >= oat_pkg::CntDepth);
  assign issue_sh = (idx_q >= oat_pkg::CntW'(pos_q));
  assign issue_sc = (idx_q < count_q);
  assign match    = (ram_rdata == value_q);
  assign is_del   = (kind_q == oat_pkg::K_DELETE);
  assign idx_m1   = idx_q - oat_pkg::CntOne;
  assign pos_m1   = pos_q - oat_pkg::PosW'(1);

  assign sts_o.kind       = kind_q;
  assign sts_o.full       = full;
  assign sts_o.pos_ok     = (pos_q != '0) && (oat_pkg::CntW'(pos_q) <= count_q);
  assign sts_o.rd_ok      = (oat_pkg::CntW'(pos_q) < count_q);
  assign sts_o.shift_busy = issue_sh || rv_q;
  assign sts_o.scan_busy  = issue_sc || rv_q;
  assign sts_o.hit        = hit_q;
  assign sts_o.out_free   = !out_valid_q || out_tready_i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q[oat_pkg::AddrW-1:0];
    if (cmd_i.app_wr) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[oat_pkg::AddrW-1:0];
      ram_wdata = value_q;
    end
    if (cmd_i.shift_step) begin
      ram_re    = issue_sh;
      ram_raddr = idx_m1[oat_pkg::AddrW-1:0];
      ram_we    = rv_q;
    end
    if (cmd_i.ins_fin) begin
      ram_we    = 1'b1;
      ram_waddr = pos_m1[oat_pkg::AddrW-1:0];
      ram_wdata = value_q;
    end
    // scan reads every entry; on delete, every entry after the hit moves down one slot
    if (cmd_i.scan_step) begin
      ram_re    = issue_sc;
      ram_we    = rv_q && hit_q && is_del;
      ram_waddr = tgt_q - oat_pkg::AddrW'(1);
    end
    if (cmd_i.rd_issue) begin
      ram_re    = 1'b1;
      ram_raddr = pos_q[oat_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= oat_pkg::CapReset;
      count_q <= '0;
      idx_q   <= '0;
      rv_q    <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.app_wr || cmd_i.ins_fin) begin
        count_q <= count_q + oat_pkg::CntOne;
      end else if (cmd_i.clr) begin
        count_q <= '0;
      end else if (cmd_i.scan_fin && hit_q && is_del) begin
        count_q <= count_q - oat_pkg::CntOne;
      end
      if (cmd_i.ins_start) begin
        idx_q <= count_q;
        rv_q  <= 1'b0;
      end else if (cmd_i.scan_start) begin
        idx_q <= '0;
        rv_q  <= 1'b0;
        hit_q <= 1'b0;
      end else if (cmd_i.shift_step) begin
        rv_q <= issue_sh;
        if (issue_sh) begin
          idx_q <= idx_m1;
        end
      end else if (cmd_i.scan_step) begin
        rv_q <= issue_sc;
        if (issue_sc) begin
          idx_q <= idx_q + oat_pkg::CntOne;
        end
        if (rv_q && !hit_q && match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q  <= oat_pkg::kind_e'(in_tuser_i);
      value_q <= in_tdata_i[oat_pkg::WordW-1:0];
      pos_q   <= in_tdata_i[oat_pkg::WordW +: oat_pkg::PosW];
    end
    if (cmd_i.st_load) begin
      status_q <= cmd_i.st_code;
    end
    if ((cmd_i.shift_step && issue_sh) || (cmd_i.scan_step && issue_sc)) begin
      tgt_q <= idx_q[oat_pkg::AddrW-1:0];
    end
    if (cmd_i.scan_step && rv_q && !hit_q && match) begin
      hit_idx_q <= tgt_q;
    end
  end

  // result fields
  always_comb begin
    rd_res = '0;
    if (kind_q == oat_pkg::K_READ) begin
      rd_res = (status_q == oat_pkg::ST_OK) ? ram_rdata : '1;
    end
    found_res = '1;
    if ((is_del || (kind_q == oat_pkg::K_SEARCH)) && hit_q) begin
      found_res = oat_pkg::FoundW'(hit_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_data_q <= {{oat_pkg::OutPadW{1'b0}}, full, (count_q == '0), count_q,
                     rd_res, found_res, status_q};
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;

  `OAT_ASSERT_IMP(a_count_range, 1'b1, count_q <= oat_pkg::CntDepth, "fill count above depth")
  `OAT_ASSERT_NXT(a_append_inc, cmd_i.app_wr, count_q == $past(count_q) + oat_pkg::CntOne, "append did not grow count")
  `OAT_ASSERT_NXT(a_delete_dec, cmd_i.scan_fin && hit_q && is_del, (count_q + oat_pkg::CntOne) == $past(count_q), "delete did not shrink count")
  `OAT_ASSERT_NXT(a_hit_sticky, cmd_i.scan_step && hit_q, hit_q && (hit_idx_q == $past(hit_idx_q)), "first match lost during scan")

endmodule

`default_nettype wire

@@ rtl/ordered_array_table_unit.sv @@
// ordered array table: a 16-entry table of signed 32-bit words with a fill count
// requests enter on the s_axis channel, kind in tuser and value/position in tdata;
// every request gives exactly one result on the m_axis channel
// the capacity register is written on the cfg channel; the user must write it only
// while the block is idle, the block itself does not enforce it
// append, read, clear and unused kinds go from the decide state straight to the
// result state; insert walks the entries from the count down to the position,
// delete and search walk all filled entries, one entry per cycle, over the entry ram
// with its separate read and write ports; one request is worked on at a time;
// s_axis_tready rises again as soon as the result sits in the output register,
// so the next request can start while the receiver has not yet taken the previous result
// the next request is accepted in the cycle after the result is loaded, at the earliest
// if the receiver stalls, the result holds in the output register and the block
// waits at the end of the next request until that register is free
// reset empties the table (count zero) and sets the capacity to 16; entry storage
// is not cleared, entries beyond the count are never read
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_table_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // value [31:0], position [36:32], zero pad [39:37]
  input  wire logic [oat_pkg::InTdataW-1:0]   s_axis_tdata,
  // kind [2:0]
  input  wire logic [oat_pkg::KindW-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // status [1:0], found_index [6:2], read_value [38:7], count [43:39],
  // empty_res [44], full_res [45], zero pad [47:46]
  output logic [oat_pkg::OutTdataW-1:0]       m_axis_tdata,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [oat_pkg::CapW-1:0]       cfg_data_i
);

  oat_pkg::dp_cmd_t cmd;
  oat_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  oat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  oat_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ verif/ordered_array_table_unit_test.sv @@
`timescale 1ns / 1ps

module ordered_array_table_unit_test;
  import oat_pkg::*;

  localparam logic [KindW-1:0] KindSpare6 = 3'd6;
  localparam logic [KindW-1:0] KindSpare7 = 3'd7;
  localparam logic [FoundW-1:0] FoundNone = 5'h1f;
  localparam logic [WordW-1:0] ReadBad = 32'hffff_ffff;
  localparam int TableDepth = 16;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CntW-1:0]   count;
    logic [WordW-1:0]  rdata;
    logic [FoundW-1:0] found;
    logic [1:0]        status;
  } table_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [KindW-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CapW-1:0]      cfg_data_i = '0;

  logic [WordW-1:0] words_q [TableDepth];
  int               fill_q = 0;
  logic [CapW-1:0]  cap_q = CapReset;
  table_result_t    pending_results [$];
  int               fail_count = 0;
  bit               idle_on = 1'b1;

  ordered_array_table_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("FAIL ordered_array_table_unit");
    $finish;
  end

  function automatic bit table_is_full();
    int lim;
    lim = (cap_q > TableDepth) ? TableDepth : int'(cap_q);
    return fill_q >= lim;
  endfunction

  function automatic table_result_t table_apply(input logic [KindW-1:0] kind,
                                                input logic [WordW-1:0] word,
                                                input logic [PosW-1:0] pos);
    table_result_t r;
    int p;
    int hit;
    p = int'(pos);
    hit = -1;
    r = '0;
    r.status = ST_OK;
    r.found = FoundNone;
    case (kind)
      K_APPEND: begin
        if (table_is_full()) begin
          r.status = ST_FULL;
        end else begin
          words_q[fill_q] = word;
          fill_q++;
        end
      end
      K_INSERT: begin
        if (table_is_full()) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > fill_q) begin
          r.status = ST_BADIDX;
        end else begin
          for (int i = fill_q; i >= p; i--) words_q[i] = words_q[i-1];
          words_q[p-1] = word;
          fill_q++;
        end
      end
      K_DELETE, K_SEARCH: begin
        for (int i = 0; i < fill_q; i++) begin
          if (hit < 0 && words_q[i] == word) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found = hit[FoundW-1:0];
          if (kind == K_DELETE) begin
            for (int i = hit; i + 1 < fill_q; i++) words_q[i] = words_q[i+1];
            fill_q--;
          end
        end
      end
      K_READ: begin
        if (p < fill_q) begin
          r.rdata = words_q[p];
        end else begin
          r.status = ST_BADIDX;
          r.rdata = ReadBad;
        end
      end
      K_CLEAR: begin
        fill_q = 0;
      end
      default: ;
    endcase
    r.count = fill_q[CntW-1:0];
    r.empty = (fill_q == 0);
    r.full = table_is_full();
    return r;
  endfunction

  task automatic push_request(input logic [KindW-1:0] kind, input logic [WordW-1:0] word,
                              input logic [PosW-1:0] pos);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {3'b000, pos, word};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(table_apply(kind, word, pos));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_q = cap;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] want,
                             input logic [WordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : result_checker
    table_result_t got;
    table_result_t want;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = table_result_t'(m_axis_tdata[$bits(table_result_t)-1:0]);
        if (pending_results.size() == 0) begin
          $error("result with no request pending: %0h", m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("found_index", want.found, got.found);
          check_field("read_value", want.rdata, got.rdata);
          check_field("count", want.count, got.count);
          check_field("empty_res", want.empty, got.empty);
          check_field("full_res", want.full, got.full);
        end
      end
      // receiver stalls
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
        m_axis_tready <= 1'b0;
      end
    end
  end

  task automatic test_empty_table();
    push_request(K_READ, 32'h0, 5'd0);
    push_request(K_DELETE, 32'h0, 5'd0);
    push_request(K_SEARCH, 32'h1, 5'd0);
    push_request(K_INSERT, 32'h2, 5'd1);
  endtask

  task automatic test_edge_values();
    push_request(K_APPEND, 32'h7fff_ffff, 5'd0);
    push_request(K_APPEND, 32'h8000_0000, 5'd0);
    push_request(K_APPEND, 32'hffff_ffff, 5'd0);
    push_request(K_INSERT, 32'h1234_5678, 5'd0);
    push_request(K_INSERT, 32'h0, 5'd1);
    push_request(K_INSERT, 32'h5, 5'd5);
    push_request(K_INSERT, 32'h5, 5'd31);
    push_request(K_SEARCH, 32'h8000_0000, 5'd0);
    push_request(K_DELETE, 32'hffff_ffff, 5'd0);
    push_request(K_DELETE, 32'h0001_2345, 5'd0);
    push_request(K_READ, 32'h0, 5'd0);
    push_request(K_READ, 32'h0, 5'd31);
    push_request(KindSpare6, 32'hffff_ffff, 5'd31);
    push_request(KindSpare7, 32'h0, 5'd0);
  endtask

  task automatic test_capacity_limits();
    // capacity below the count keeps the table full
    write_capacity(5'd2);
    push_request(K_READ, 32'h0, 5'd1);
    push_request(K_DELETE, 32'h7fff_ffff, 5'd0);
    push_request(K_APPEND, 32'h9, 5'd0);
    push_request(K_INSERT, 32'h9, 5'd1);
    write_capacity(5'd0);
    push_request(K_CLEAR, 32'h0, 5'd0);
    push_request(K_APPEND, 32'h3, 5'd0);
    write_capacity(5'd31);
    push_request(K_APPEND, 32'h4, 5'd0);
  endtask

  task automatic test_random_mix(input int n, input logic [CapW-1:0] cap, input bit idle);
    logic [WordW-1:0] pool [8];
    int pick;
    logic [KindW-1:0] kind;
    logic [WordW-1:0] word;
    logic [PosW-1:0] pos;
    write_capacity(cap);
    idle_on = idle;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0;
    pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) pool[i] = $urandom();
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = K_APPEND;
      else if (pick < 50) kind = K_INSERT;
      else if (pick < 65) kind = K_DELETE;
      else if (pick < 80) kind = K_SEARCH;
      else if (pick < 95) kind = K_READ;
      else if (pick < 97) kind = K_CLEAR;
      else if (pick < 99) kind = KindSpare6;
      else kind = KindSpare7;
      word = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, 7)] : $urandom();
      if ($urandom_range(0, 9) == 0) pos = PosW'($urandom_range(0, 31));
      else pos = PosW'($urandom_range(0, fill_q + 1));
      push_request(kind, word, pos);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_edge_values();
    test_capacity_limits();
    test_random_mix(150, 5'd16, 1'b1);
    test_random_mix(60, 5'd1, 1'b1);
    test_random_mix(40, 5'd0, 1'b1);
    test_random_mix(150, 5'd31, 1'b1);
    test_random_mix(130, 5'd5, 1'b1);
    test_random_mix(100, 5'd2, 1'b1);
    test_random_mix(150, 5'($urandom_range(3, 15)), 1'b1);
    test_random_mix(150, 5'($urandom_range(17, 30)), 1'b1);
    test_random_mix(150, 5'd12, 1'b1);
    test_random_mix(150, 5'd16, 1'b1);
    test_random_mix(150, 5'd16, 1'b0);
    drain_results();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS ordered_array_table_unit");
    end else begin
      $display("FAIL ordered_array_table_unit");
    end
    $finish;
  end

endmodule
